@@ rtl/core/maf_pkg.sv @@
// ----------------------------------------------------------------------------
// maf_pkg: moving average filter shared types and constants
// Count width and controller state encoding for the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

  // width of the window length register and of the sample count
  localparam int CNT_W = 7;

  // largest value the count field can carry
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  // window length after reset
  localparam int WL_RESET = 64;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } maf_state_t;

endpackage

@@ rtl/core/moving_average_filter_unit.sv @@
// ----------------------------------------------------------------------------
// moving_average_filter_unit: simple moving average of signed samples
// Keeps a ring of the last window_length samples and a running sum, and
// returns the truncated mean of the samples held so far for every sample.
// ----------------------------------------------------------------------------
// Usage
//   s_* channel: one signed sample per beat (tdata, sample in the low bits).
//   m_* channel: one result beat per sample: mean and samples_in_window.
//   cfg_* channel: writes window_length (0 is taken as 1, values above
//   MAX_WINDOW as MAX_WINDOW); a write clears the stored window, the slot
//   pointer and the running sum. Write it only while the block is idle.
// Sample flow
//   the ring read happens at the accept edge; ST_SUM then updates the
//   running sum, ST_DIV runs the bit-serial restoring divider (one
//   quotient bit per cycle) and ST_OUT loads the output register. The
//   divider sets the rate: s_tready rises again once the result has moved
//   to the output register, so a new sample is taken only after the
//   previous one has left the divider.
// Reset and stall
//   rst clears the window, count, slot pointer and sum and sets
//   window_length to 64 (or MAX_WINDOW if smaller). The ring needs no clear.
//   A new sample is taken while a result still waits in the output
//   register; a finished result waits in the divider until m_tready frees it.
// ----------------------------------------------------------------------------
module moving_average_filter_unit
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32,
  localparam int IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // input samples
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // sample
  // results
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // mean, samples_in_window
  // window length register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data   // window_length
);

  localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int WL_CAP = (MAX_WINDOW > CNT_MAX) ? CNT_MAX : MAX_WINDOW;
  localparam int WL_RST = (WL_RESET > MAX_WINDOW) ? MAX_WINDOW : WL_RESET;
  localparam int PAD_W  = OUT_W - SAMPLE_WIDTH - CNT_W;

  // sample ring
  logic [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] ring_rd;

  // control state
  maf_state_t state, state_next;
  logic [CNT_W-1:0]  window_length;
  logic [CNT_W-1:0]  fill_count;
  logic [IDX_W-1:0]  write_slot;
  logic [SUM_W-1:0]  running_sum;

  // per-item datapath
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    full;
  logic [SUM_W-1:0]        dvd;
  logic [CNT_W-1:0]        rem;
  logic                    neg;
  logic [DCNT_W-1:0]       dcnt;

  // output register
  logic                    out_valid;
  logic [SAMPLE_WIDTH-1:0] out_mean;
  logic [CNT_W-1:0]        out_count;

  // handshakes
  logic in_acc, cfg_acc, out_load;

  // combinational helpers
  logic [CNT_W-1:0]  cfg_wl;
  logic [IDX_W-1:0]  slot_cur;
  logic [IDX_W-1:0]  slot_nxt;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [SAMPLE_WIDTH-1:0] q_mag;

  assign cfg_ready = (state == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = s_tvalid && s_tready;

  // window length clamp
  always_comb begin
    if (cfg_data == '0) begin
      cfg_wl = CNT_W'(1);
    end else if (int'(cfg_data) > WL_CAP) begin
      cfg_wl = CNT_W'(WL_CAP);
    end else begin
      cfg_wl = cfg_data;
    end
  end

  // slot selection and advance
  always_comb begin
    if (int'(write_slot) >= int'(window_length)) begin
      slot_cur = '0;
    end else begin
      slot_cur = write_slot;
    end
    if (int'(slot_cur) + 1 >= int'(window_length)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = IDX_W'(int'(slot_cur) + 1);
    end
  end

  // running sum update: add new sample, drop oldest when the window is full
  always_comb begin
    sum_next = running_sum + {{CNT_W{sample[SAMPLE_WIDTH-1]}}, sample};
    if (full) begin
      sum_next = sum_next - {{CNT_W{ring_rd[SAMPLE_WIDTH-1]}}, ring_rd};
    end
  end

  // one restoring division step
  always_comb begin
    rem_sh = {rem, dvd[SUM_W-1]};
    rem_ge = (rem_sh >= {1'b0, fill_count});
    q_mag  = dvd[SAMPLE_WIDTH-1:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !cfg_valid;
        if (s_tvalid && !cfg_valid) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (dcnt == DCNT_W'(1)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ring write and registered read of the slot being replaced
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_rd          <= ring[slot_cur];
      ring[slot_cur]   <= s_tdata[SAMPLE_WIDTH-1:0];
    end
  end

  // window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CNT_W'(WL_RST);
      fill_count    <= '0;
      write_slot    <= '0;
      running_sum   <= '0;
    end else if (cfg_acc) begin
      window_length <= cfg_wl;
      fill_count    <= '0;
      write_slot    <= '0;
      running_sum   <= '0;
    end else begin
      if (in_acc) begin
        write_slot <= slot_nxt;
        if (fill_count < window_length) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
      if (state == ST_SUM) begin
        running_sum <= sum_next;
      end
    end
  end

  // sample capture, sum magnitude and bit-serial divider
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample <= s_tdata[SAMPLE_WIDTH-1:0];
      full   <= (fill_count >= window_length);
    end
    if (state == ST_SUM) begin
      neg  <= sum_next[SUM_W-1];
      dvd  <= sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;
      rem  <= '0;
      dcnt <= DCNT_W'(SUM_W);
    end else if (state == ST_DIV) begin
      dvd  <= {dvd[SUM_W-2:0], rem_ge};
      rem  <= rem_ge ? CNT_W'(rem_sh - {1'b0, fill_count}) : rem_sh[CNT_W-1:0];
      dcnt <= dcnt - DCNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean  <= neg ? (~q_mag + SAMPLE_WIDTH'(1)) : q_mag;
      out_count <= fill_count;
    end
  end

  assign m_tvalid = out_valid;

  // result beat packing
  generate
    if (PAD_W > 0) begin : g_pad
      assign m_tdata = {{PAD_W{1'b0}}, out_count, out_mean};
    end else begin : g_nopad
      assign m_tdata = {out_count, out_mean};
    end
  endgenerate

endmodule
